/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files of the subset stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/nsub_pkg.sv */
// Package with shared constants and types of the subset stepper.
`timescale 1ns / 1ps

package nsub_pkg;

  // default automaton size
  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_LETTERS_DEF = 8;

  // fixed port widths
  localparam int OP_W    = 2;
  localparam int INDEX_W = 4;
  localparam int LETTER_W = 4;
  localparam int MASK_W  = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_ROW = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP      = 2'd2;

  // letter code of the epsilon rows
  localparam logic [LETTER_W-1:0] LETTER_EPS = 4'd0;

  // table port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

endpackage

/* hdl/nfa_subset_step.sv */
// Top level of the NFA subset stepper: command handling and closure sequencer.
//
// Usage: an item is transferred at a rising edge with start high and busy low.
// operation 0 writes the row of (state_index, letter); 1 loads the active set
// with the epsilon closure of set_mask; 2 steps the active set on letter.
// Each item gives one result: done is high for one cycle with active_set and
// is_empty valid in that cycle. The receiver cannot stall; results must be
// taken when shown. A new item may be started in the cycle done is high.
// A row write, an unknown code or a step on epsilon or an unknown letter gives
// done in the cycle after the transfer. The single table read port serves one
// row per cycle, and a state found by a read can be picked once the registered
// read data has been merged into the work set. A load closes set_mask over the
// epsilon rows; a step first gathers the letter rows of the active states and
// then closes the gathered set over the epsilon rows.
// Reset: the active set clears and a sweep zeroes the table, one row per
// cycle, over NUM_STATES * (NUM_LETTERS + 1) rows (144 at the default size);
// busy stays high during the sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nfa_subset_step #(
  parameter int NUM_STATES  = nsub_pkg::NUM_STATES_DEF,
  parameter int NUM_LETTERS = nsub_pkg::NUM_LETTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [nsub_pkg::OP_W-1:0]     operation,
  input  logic [nsub_pkg::INDEX_W-1:0]  state_index,
  input  logic [nsub_pkg::LETTER_W-1:0] letter,
  input  logic [nsub_pkg::MASK_W-1:0]   set_mask,
  output logic                          done,
  output logic [nsub_pkg::MASK_W-1:0]   active_set,
  output logic                          is_empty
);

  localparam int ROW_LEN = NUM_LETTERS + 1;
  localparam int ROWS    = NUM_STATES * ROW_LEN;
  localparam int AW      = $clog2(ROWS);
  localparam int SW      = $clog2(NUM_STATES);
  localparam int MW      = nsub_pkg::MASK_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_CLOSE  = 3'b100
  } state_t;

  state_t                         state;
  logic [NUM_STATES-1:0]          cur;
  logic [NUM_STATES-1:0]          work;
  logic [NUM_STATES-1:0]          seen;
  logic [nsub_pkg::LETTER_W-1:0]  let_q;
  logic                           inflight;

  logic                           accept;
  logic                           done_next;
  logic                           clearing;
  logic                           row_ok;
  logic                           letter_ok;
  logic [NUM_STATES-1:0]          in_mask;
  logic [NUM_STATES-1:0]          pend;
  logic                           pick_any;
  logic [NUM_STATES-1:0]          pick_onehot;
  logic [SW-1:0]                  pick_idx;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic [NUM_STATES-1:0]          rd_data;
  nsub_pkg::tbl_ctl_t             tbl_ctl;

  // fit the mask port to the automaton width
  for (genvar i = 0; i < NUM_STATES; i++) begin : g_in_mask
    if (i < MW) begin : g_bit
      assign in_mask[i] = set_mask[i];
    end else begin : g_zero
      assign in_mask[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < MW; i++) begin : g_out_mask
    if (i < NUM_STATES) begin : g_bit
      assign active_set[i] = cur[i];
    end else begin : g_zero
      assign active_set[i] = 1'b0;
    end
  end

  assign is_empty = (active_set == '0);

  // command decode
  assign busy      = (state != S_IDLE) || clearing;
  assign accept    = start && !busy;
  assign row_ok    = (int'(state_index) < NUM_STATES) && (int'(letter) <= NUM_LETTERS);
  assign letter_ok = (letter != nsub_pkg::LETTER_EPS) && (int'(letter) <= NUM_LETTERS);

  // result strobe: commands that finish at once, or a closure that has run dry
  assign done_next = (accept && (operation != nsub_pkg::OP_LOAD) &&
                      !((operation == nsub_pkg::OP_STEP) && letter_ok)) ||
                     ((state == S_CLOSE) && !pick_any && !inflight);

  // pending states: active set while gathering targets, closure set otherwise
  assign pend = ((state == S_GATHER) ? cur : work) & ~seen;

  nsub_pick #(
    .NUM_STATES (NUM_STATES)
  ) u_pick (
    .pend   (pend),
    .any    (pick_any),
    .onehot (pick_onehot),
    .index  (pick_idx)
  );

  // table addressing: gather reads the step letter, closure the epsilon row
  always_comb begin
    tbl_ctl.rd_en = ((state == S_GATHER) || (state == S_CLOSE)) && pick_any;
    tbl_ctl.wr_en = accept && (operation == nsub_pkg::OP_WRITE_ROW) && row_ok;
    rd_addr = AW'(int'(pick_idx) * ROW_LEN +
                  ((state == S_GATHER) ? int'(let_q) : int'(nsub_pkg::LETTER_EPS)));
    wr_addr = AW'(int'(state_index) * ROW_LEN + int'(letter));
  end

  nsub_table #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tbl_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (in_mask),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      inflight <= 1'b0;
      cur      <= '0;
    end else begin
      done     <= done_next;
      inflight <= tbl_ctl.rd_en;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              nsub_pkg::OP_LOAD: begin
                work  <= in_mask;
                seen  <= '0;
                state <= S_CLOSE;
              end
              nsub_pkg::OP_STEP: begin
                if (letter_ok) begin
                  work  <= '0;
                  seen  <= '0;
                  let_q <= letter;
                  state <= S_GATHER;
                end
              end
              default: ;
            endcase
          end
        end
        S_GATHER: begin
          if (inflight) begin
            work <= work | rd_data;
          end
          if (pick_any) begin
            seen <= seen | pick_onehot;
          end else if (!inflight) begin
            seen  <= '0;
            state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (inflight) begin
            work <= work | rd_data;
          end
          if (pick_any) begin
            seen <= seen | pick_onehot;
          end else if (!inflight) begin
            cur   <= work;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_RST(a_idle_no_read, clk, rst, (state == S_IDLE) |-> (!inflight && !tbl_ctl.rd_en),
              "table read pending while idle")
  `ASSERT_RST(a_accept_progress, clk, rst, accept |=> (busy || done),
              "transfer neither started work nor gave a result")
  `ASSERT_RST(a_done_when_idle, clk, rst, done |-> (state == S_IDLE),
              "result strobe outside idle state")

endmodule

/* hdl/nsub_pick.sv */
// Lowest-pending-state picker: isolates the lowest set bit and encodes it.
`timescale 1ns / 1ps

module nsub_pick #(
  parameter int NUM_STATES = nsub_pkg::NUM_STATES_DEF
) (
  input  logic [NUM_STATES-1:0]         pend,
  output logic                          any,
  output logic [NUM_STATES-1:0]         onehot,
  output logic [$clog2(NUM_STATES)-1:0] index
);

  localparam int SW = $clog2(NUM_STATES);

  assign any    = |pend;
  // two's complement trick keeps only the lowest set bit
  assign onehot = pend & (~pend + NUM_STATES'(1));

  // encode the one-hot word
  always_comb begin
    index = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (onehot[i]) begin
        index = index | SW'(i);
      end
    end
  end

endmodule

/* hdl/nsub_table.sv */
// Transition table memory with a clearing sweep after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsub_table #(
  parameter int NUM_STATES  = nsub_pkg::NUM_STATES_DEF,
  parameter int NUM_LETTERS = nsub_pkg::NUM_LETTERS_DEF,
  localparam int ROWS = NUM_STATES * (NUM_LETTERS + 1),
  localparam int AW   = $clog2(ROWS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  nsub_pkg::tbl_ctl_t    ctl,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic [NUM_STATES-1:0] wr_data,
  output logic [NUM_STATES-1:0] rd_data,
  output logic                  clearing
);

  logic [NUM_STATES-1:0] mem [ROWS];
  logic [AW-1:0]         clr_addr;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (int'(clr_addr) == ROWS - 1) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  `ASSERT_RST(a_no_access_in_clear, clk, rst, (ctl.rd_en || ctl.wr_en) |-> !clearing,
              "table accessed during clearing sweep")
  `ASSERT_RST(a_addr_in_range, clk, rst,
              (ctl.wr_en |-> (int'(wr_addr) < ROWS)) and (ctl.rd_en |-> (int'(rd_addr) < ROWS)),
              "table address beyond last row")

endmodule
